@@ rtl/fft_pkg.sv @@
package fft_pkg;

  localparam int unsigned DefMaxPoints = 64;
  localparam int unsigned DefSampleBits = 16;
  localparam int unsigned TableLog = 6;
  localparam int unsigned CfgSizeAddr = 0;
  localparam int unsigned CfgInvAddr = 1;

  // Quarter-wave cosine magnitudes, Q1.15 with 1.0 held as 32768.
  function automatic logic [16:0] quarter_cos(input logic [4:0] a);
    logic [16:0] v;
    begin
      case (a)
        5'd0: v = 17'd32768;
        5'd1: v = 17'd32610;
        5'd2: v = 17'd32138;
        5'd3: v = 17'd31357;
        5'd4: v = 17'd30274;
        5'd5: v = 17'd28899;
        5'd6: v = 17'd27246;
        5'd7: v = 17'd25330;
        5'd8: v = 17'd23170;
        5'd9: v = 17'd20788;
        5'd10: v = 17'd18205;
        5'd11: v = 17'd15447;
        5'd12: v = 17'd12540;
        5'd13: v = 17'd9512;
        5'd14: v = 17'd6393;
        5'd15: v = 17'd3212;
        default: v = 17'd0;
      endcase
      return v;
    end
  endfunction

  typedef struct packed {
    logic signed [17:0] c;
    logic signed [17:0] s;
  } twiddle_t;

  // Twiddle angle index a covers 2*pi*a/64, a in 0..31.
  function automatic twiddle_t twiddle(input logic [4:0] a);
    twiddle_t t;
    begin
      if (a <= 5'd16) begin
        t.c = signed'({1'b0, quarter_cos(a)});
        t.s = signed'({1'b0, quarter_cos(5'd16 - a)});
      end else begin
        t.c = -signed'({1'b0, quarter_cos(5'd0 - a)});
        t.s = signed'({1'b0, quarter_cos(a - 5'd16)});
      end
      return t;
    end
  endfunction

endpackage

@@ rtl/radix2_fft.sv @@
// After the last sample of a frame, N/2*log2(N) butterflies run, each in the steps
// read a, read b, multiply, write a, write b (one read port and one write port),
// then the bins are read out in order, each held until the receiver takes it.
// A stalled bin holds the sequencer, and no sample is taken until the frame is out.
// Reset: asynchronous, active low; clears the sequencer, size_log2 to 6, inverse to 0.
module radix2_fft import fft_pkg::*; #(
  parameter int unsigned MAX_POINTS = DefMaxPoints,
  parameter int unsigned SAMPLE_BITS = DefSampleBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          sample_valid_i,
  output logic                          sample_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_real_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_imag_i,
  output logic                          bin_valid_o,
  input  logic                          bin_ready_i,
  output logic signed [SAMPLE_BITS+5:0] bin_real_o,
  output logic signed [SAMPLE_BITS+5:0] bin_imag_o,
  output logic                          last_bin_o
);
  localparam int unsigned BinBits = SAMPLE_BITS + 6;
  localparam int unsigned AW = (MAX_POINTS > 32) ? 6 : (MAX_POINTS > 16) ? 5 :
                               (MAX_POINTS > 8) ? 4 : (MAX_POINTS > 4) ? 3 :
                               (MAX_POINTS > 2) ? 2 : 1;
  localparam int unsigned MaxLog = AW;

  typedef enum logic [3:0] {
    S_LOAD, S_RD_A, S_RD_B, S_MUL, S_WR_X, S_WR_Y, S_OUT_RD, S_OUT_PUT, S_DRAIN
  } state_e;

  state_e state_q;
  logic [2:0] size_q;
  logic inv_q;
  logic [AW:0] cnt_q;
  logic [2:0] stage_q;
  logic [AW-1:0] grp_q, k_q;
  logic [BinBits-1:0] mem_r [MAX_POINTS];
  logic [BinBits-1:0] mem_i [MAX_POINTS];
  logic signed [BinBits-1:0] rd_r_q, rd_i_q, a_r_q, a_i_q, y_r_q, y_i_q;
  logic signed [BinBits-1:0] xr, xi, yr, yi;
  logic [AW-1:0] ia, ib, rev_idx;
  logic [2:0] lg;
  logic [AW:0] npts;
  logic [AW-1:0] half;
  twiddle_t w, w_q;
  logic out_v_q, out_last_q;
  logic cfg_wr;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic wr_en;
  logic [BinBits-1:0] wr_r, wr_i;
  logic grp_done, k_done, bin_last, out_free;

  always_comb begin
    lg = size_q;
    if (lg < 3'd1) lg = 3'd1;
    if (lg > 3'(MaxLog)) lg = 3'(MaxLog);
    npts = (AW+1)'(1) << lg;
    half = AW'((AW+1)'(1) << (stage_q - 3'd1));
    // Butterfly index: group base plus offset k.
    ia = AW'((grp_q << stage_q) + k_q);
    ib = ia + half;
    grp_done = (((AW+1)'(grp_q) + (AW+1)'(1)) << stage_q) >= npts;
    k_done = (k_q + AW'(1)) == half;
    bin_last = (cnt_q + 1'b1) == npts;
    rev_idx = '0;
    for (int b = 0; b < AW; b++) begin
      if (3'(b) < lg) rev_idx[lg - 3'(b) - 3'd1] = cnt_q[b];
    end
    w = twiddle(5'(k_q << (3'(TableLog) - stage_q)));
    if (inv_q) w.s = -w.s;
  end

  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    if (paddr[2] == 1'(CfgInvAddr)) prdata[0] = inv_q;
    else prdata[2:0] = size_q;
  end

  fft_bfly #(.BinBits(BinBits)) u_bfly (
    .clk_i(clk_i), .ar_i(a_r_q), .ai_i(a_i_q), .br_i(rd_r_q), .bi_i(rd_i_q),
    .w_i(w_q), .xr_o(xr), .xi_o(xi), .yr_o(yr), .yi_o(yi)
  );

  // Samples land at bit-reversed addresses, so no separate reordering pass is needed.
  always_comb begin
    wr_en = 1'b0;
    wr_addr = rev_idx;
    wr_r = BinBits'(sample_real_i);
    wr_i = BinBits'(sample_imag_i);
    rd_addr = ia;
    if (state_q == S_LOAD) begin
      wr_en = sample_valid_i;
    end else if (state_q == S_RD_B) begin
      rd_addr = ib;
    end else if (state_q == S_WR_X) begin
      wr_en = 1'b1;
      wr_addr = ia;
      wr_r = xr;
      wr_i = xi;
    end else if (state_q == S_WR_Y) begin
      wr_en = 1'b1;
      wr_addr = ib;
      wr_r = y_r_q;
      wr_i = y_i_q;
    end else if (state_q == S_OUT_RD || state_q == S_OUT_PUT) begin
      rd_addr = AW'(cnt_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_r;
      mem_i[wr_addr] <= wr_i;
    end
    rd_r_q <= mem_r[rd_addr];
    rd_i_q <= mem_i[rd_addr];
    // The a operand and twiddle wait here while b is read; b feeds the multiplier
    // straight from the read register in S_MUL.
    if (state_q == S_RD_B) begin
      a_r_q <= rd_r_q;
      a_i_q <= rd_i_q;
      w_q <= w;
    end
    if (state_q == S_WR_X) begin
      y_r_q <= yr;
      y_i_q <= yi;
    end
  end

  assign sample_ready_o = (state_q == S_LOAD);
  assign bin_valid_o = out_v_q;
  assign last_bin_o = out_last_q;
  assign out_free = !out_v_q || bin_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      size_q <= 3'd6;
      inv_q <= 1'b0;
      cnt_q <= '0;
      stage_q <= 3'd1;
      grp_q <= '0;
      k_q <= '0;
      out_v_q <= 1'b0;
      out_last_q <= 1'b0;
      bin_real_o <= '0;
      bin_imag_o <= '0;
    end else begin
      if (out_v_q && bin_ready_i) out_v_q <= 1'b0;
      unique case (state_q)
        S_LOAD: begin
          if (sample_valid_i) begin
            if (cnt_q + 1'b1 == npts) begin
              cnt_q <= '0;
              stage_q <= 3'd1;
              grp_q <= '0;
              k_q <= '0;
              state_q <= S_RD_A;
            end else cnt_q <= cnt_q + 1'b1;
          end
        end
        S_RD_A: state_q <= S_RD_B;
        S_RD_B: state_q <= S_MUL;
        S_MUL: state_q <= S_WR_X;
        S_WR_X: state_q <= S_WR_Y;
        S_WR_Y: begin
          state_q <= S_RD_A;
          if (grp_done) begin
            grp_q <= '0;
            if (k_done) begin
              k_q <= '0;
              if (stage_q == lg) state_q <= S_OUT_RD;
              else stage_q <= stage_q + 3'd1;
            end else k_q <= k_q + 1'b1;
          end else grp_q <= grp_q + 1'b1;
        end
        S_OUT_RD: state_q <= S_OUT_PUT;
        S_OUT_PUT: begin
          if (out_free) begin
            bin_real_o <= rd_r_q;
            bin_imag_o <= rd_i_q;
            out_v_q <= 1'b1;
            out_last_q <= bin_last;
            if (bin_last) state_q <= S_DRAIN;
            else begin
              cnt_q <= cnt_q + 1'b1;
              state_q <= S_OUT_RD;
            end
          end
        end
        // Loading resumes only once the last bin has been handed over.
        S_DRAIN: begin
          if (out_free) begin
            cnt_q <= '0;
            state_q <= S_LOAD;
          end
        end
        default: state_q <= S_LOAD;
      endcase
      if (cfg_wr && paddr[2] == 1'(CfgSizeAddr)) begin
        size_q <= pwdata[2:0];
        cnt_q <= '0;
      end
      if (cfg_wr && paddr[2] == 1'(CfgInvAddr)) inv_q <= pwdata[0];
    end
  end

endmodule

@@ rtl/fft_bfly.sv @@
// Shared butterfly: multiply stage, then round and add/subtract stage.
module fft_bfly import fft_pkg::*; #(
  parameter int unsigned BinBits = 22
) (
  input  logic                      clk_i,
  input  logic signed [BinBits-1:0] ar_i,
  input  logic signed [BinBits-1:0] ai_i,
  input  logic signed [BinBits-1:0] br_i,
  input  logic signed [BinBits-1:0] bi_i,
  input  twiddle_t                  w_i,
  output logic signed [BinBits-1:0] xr_o,
  output logic signed [BinBits-1:0] xi_o,
  output logic signed [BinBits-1:0] yr_o,
  output logic signed [BinBits-1:0] yi_o
);
  localparam int unsigned PW = BinBits + 18;

  logic signed [PW-1:0] p_cb_q, p_sb_q, p_sr_q, p_ci_q;
  logic signed [BinBits-1:0] ar_q, ai_q;
  logic signed [PW:0] sr, si;
  logic signed [PW-15:0] tr, ti;

  always_ff @(posedge clk_i) begin
    p_cb_q <= PW'(w_i.c * br_i);
    p_sb_q <= PW'(w_i.s * bi_i);
    p_sr_q <= PW'(w_i.s * br_i);
    p_ci_q <= PW'(w_i.c * bi_i);
    ar_q <= ar_i;
    ai_q <= ai_i;
  end

  always_comb begin
    sr = (PW+1)'(p_cb_q) - (PW+1)'(p_sb_q) + (PW+1)'(16384);
    si = (PW+1)'(p_sr_q) + (PW+1)'(p_ci_q) + (PW+1)'(16384);
    tr = sr[PW:15];
    ti = si[PW:15];
    xr_o = ar_q + tr[BinBits-1:0];
    xi_o = ai_q + ti[BinBits-1:0];
    yr_o = ar_q - tr[BinBits-1:0];
    yi_o = ai_q - ti[BinBits-1:0];
  end
endmodule

@@ rtl/radix2_fft_chk.sv @@
module radix2_fft_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic sample_valid_i,
  input logic sample_ready_o,
  input logic bin_valid_o,
  input logic bin_ready_i,
  input logic last_bin_o,
  input logic pready
);
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(sample_ready_o && bin_valid_o)) else $error("loading while emitting");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bin_valid_o && !bin_ready_i |=> bin_valid_o && $stable(last_bin_o))
    else $error("bin dropped");
endmodule

bind radix2_fft radix2_fft_chk u_chk (.*);
